// ===== rtl/bdwd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdwd_pkg
// shared types, constants and helpers of the big defect window detector
// ----------------------------------------------------------------------------
package bdwd_pkg;

    localparam int CFG_W    = 12;
    localparam int PIX_W    = 8;
    localparam int HIT_W    = 24;
    localparam int TDATA_W  = 32;
    localparam int WIN_W    = 25;
    localparam int HIST_W   = 7;
    localparam int COL_W    = 5;
    localparam int STORE_W  = 4;
    localparam int CNT_W    = 5;

    localparam logic [PIX_W-1:0]  DEFECT_CODE = 8'd255;
    localparam logic [CNT_W-1:0]  WINDOW_MIN  = 5'd16;
    localparam logic [HIST_W-1:0] RUN_MASK    = 7'h55;
    localparam logic [HIT_W-1:0]  HIT_MAX     = 24'hFFFFFF;

    localparam logic [CFG_W-1:0] WIDTH_DEFAULT  = 12'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_DEFAULT = 12'd1024;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic cur;
        logic c_ge4;
        logic r_ge4;
        logic c_ge6;
        logic frame_end;
    } pix_info_t;

    function automatic logic [CNT_W-1:0] popcount25(input logic [WIN_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WIN_W; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ===== rtl/bdwd_line_store.sv =====
// ----------------------------------------------------------------------------
// bdwd_line_store
// column store of the four previous rows, registered read with write forwarding
// ----------------------------------------------------------------------------
module bdwd_line_store #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
    input  logic                            wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  logic [bdwd_pkg::STORE_W-1:0]    wr_data,
    output logic [bdwd_pkg::STORE_W-1:0]    rd_data
);

    logic [bdwd_pkg::STORE_W-1:0] mem [MAX_WIDTH];
    logic [bdwd_pkg::STORE_W-1:0] rd_data_reg;
    logic [bdwd_pkg::STORE_W-1:0] fwd_data_reg;
    logic                         fwd_sel_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // same-edge read and write of one column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_sel_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_sel_reg <= wr_en && (rd_addr == wr_addr);
        end
    end

    assign rd_data = fwd_sel_reg ? fwd_data_reg : rd_data_reg;

    a_fwd_on_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wr_en && (rd_addr == wr_addr) |=> fwd_sel_reg && (rd_data == $past(wr_data)))
        else $error("write forwarding missed");

endmodule

// ===== rtl/bdwd_scan.sv =====
// ----------------------------------------------------------------------------
// bdwd_scan
// raster position tracking and the pixel stage register
// ----------------------------------------------------------------------------
module bdwd_scan #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bdwd_pkg::CFG_W-1:0]          image_width,
    input  logic [bdwd_pkg::CFG_W-1:0]          image_height,
    input  logic                                accept,
    input  logic [bdwd_pkg::PIX_W-1:0]          pixel_value,
    input  logic                                advance,
    output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
    output logic                                s1_valid,
    output bdwd_pkg::pix_info_t                 s1_info,
    output logic [$clog2(MAX_WIDTH)-1:0]        s1_addr
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WNW = $clog2(MAX_WIDTH + 1);
    localparam int HNW = $clog2(MAX_HEIGHT + 1);
    localparam int WEW = (bdwd_pkg::CFG_W > WNW) ? bdwd_pkg::CFG_W : WNW;
    localparam int HEW = (bdwd_pkg::CFG_W > HNW) ? bdwd_pkg::CFG_W : HNW;

    logic [CW-1:0]        column_reg, column_next;
    logic [RW-1:0]        row_reg, row_next;
    logic                 s1_valid_reg;
    bdwd_pkg::pix_info_t  s1_info_reg, info_next;
    logic [CW-1:0]        s1_addr_reg;

    logic [WEW-1:0] w_cfg, w_eff, c_inc;
    logic [HEW-1:0] h_cfg, h_eff, r_inc;
    logic           row_end;

    always_comb begin
        w_cfg = WEW'(image_width);
        h_cfg = HEW'(image_height);
        if (w_cfg == '0) begin
            w_eff = WEW'(1);
        end else if (w_cfg > WEW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (h_cfg == '0) begin
            h_eff = HEW'(1);
        end else if (h_cfg > HEW'(MAX_HEIGHT)) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = h_cfg;
        end

        c_inc   = WEW'(column_reg) + WEW'(1);
        r_inc   = HEW'(row_reg) + HEW'(1);
        row_end = c_inc >= w_eff;

        info_next.cur       = (pixel_value == bdwd_pkg::DEFECT_CODE);
        info_next.c_ge4     = column_reg >= CW'(4);
        info_next.r_ge4     = row_reg >= RW'(4);
        info_next.c_ge6     = column_reg >= CW'(6);
        info_next.frame_end = row_end && (r_inc >= h_eff);

        column_next = column_reg;
        row_next    = row_reg;
        if (accept) begin
            if (info_next.frame_end) begin
                column_next = '0;
                row_next    = '0;
            end else if (row_end) begin
                column_next = '0;
                row_next    = r_inc[RW-1:0];
            end else begin
                column_next = c_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (advance) begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= info_next;
            s1_addr_reg <= column_reg;
        end
    end

    assign rd_addr  = column_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_info  = s1_info_reg;
    assign s1_addr  = s1_addr_reg;

endmodule

// ===== rtl/bdwd_score.sv =====
// ----------------------------------------------------------------------------
// bdwd_score
// window and run scoring, hit total and result register
// ----------------------------------------------------------------------------
module bdwd_score (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s1_valid,
    input  bdwd_pkg::pix_info_t             s1_info,
    input  logic [bdwd_pkg::STORE_W-1:0]    old_bits,
    input  logic                            m_tready,
    output logic                            advance,
    output logic                            wr_en,
    output logic [bdwd_pkg::STORE_W-1:0]    wr_data,
    output logic                            m_tvalid,
    output logic [bdwd_pkg::HIT_W-1:0]      hit_count,
    output logic                            big_defect_found
);

    logic [bdwd_pkg::WIN_W-1:0]  window_reg, window_next;
    logic [bdwd_pkg::HIST_W-1:0] hist_reg, hist_next;
    logic [bdwd_pkg::HIT_W-1:0]  total_reg, total_next, total_sum;
    logic                        m_valid_reg;
    logic [bdwd_pkg::HIT_W-1:0]  m_count_reg;
    logic                        m_found_reg;

    logic [bdwd_pkg::COL_W-1:0]  col;
    logic                        win_hit, run_hit, consume;
    logic [bdwd_pkg::HIT_W:0]    sum_wide;

    assign advance = !(s1_valid && s1_info.frame_end && m_valid_reg && !m_tready);
    assign consume = s1_valid && advance;
    assign wr_en   = consume;
    assign col     = {old_bits, s1_info.cur};
    assign wr_data = col[bdwd_pkg::STORE_W-1:0];

    always_comb begin
        window_next = {window_reg[bdwd_pkg::WIN_W-bdwd_pkg::COL_W-1:0], col};
        hist_next   = {hist_reg[bdwd_pkg::HIST_W-2:0], s1_info.cur};
        win_hit     = s1_info.r_ge4 && s1_info.c_ge4 && window_next[12]
                      && (bdwd_pkg::popcount25(window_next) >= bdwd_pkg::WINDOW_MIN);
        run_hit     = s1_info.c_ge6
                      && ((hist_next & bdwd_pkg::RUN_MASK) == bdwd_pkg::RUN_MASK);
        sum_wide    = {1'b0, total_reg} + (bdwd_pkg::HIT_W+1)'(win_hit)
                      + (bdwd_pkg::HIT_W+1)'(run_hit);
        total_sum   = (sum_wide > {1'b0, bdwd_pkg::HIT_MAX})
                      ? bdwd_pkg::HIT_MAX : sum_wide[bdwd_pkg::HIT_W-1:0];
        total_next  = total_sum;
        if (s1_info.frame_end) begin
            window_next = '0;
            hist_next   = '0;
            total_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            hist_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (consume) begin
                window_reg <= window_next;
                hist_reg   <= hist_next;
                total_reg  <= total_next;
            end
            if (consume && s1_info.frame_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && s1_info.frame_end) begin
            m_count_reg <= total_sum;
            m_found_reg <= (total_sum != '0);
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign hit_count        = m_count_reg;
    assign big_defect_found = m_found_reg;

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && s1_info.frame_end |=> m_valid_reg)
        else $error("frame result not registered");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && s1_info.frame_end |=> (total_reg == '0) && (window_reg == '0))
        else $error("frame state not cleared");

    a_found_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_found_reg == (m_count_reg != '0)))
        else $error("found flag disagrees with count");

endmodule

// ===== rtl/big_defect_window_detect.sv =====
// ----------------------------------------------------------------------------
// big_defect_window_detect
// counts 5x5 window and row run defect hits per frame of a defect map
// ----------------------------------------------------------------------------
// one pixel per cycle sustained, set by the read-modify-write of the column
// line store (one read and one write port, forwarded on a same-column hit)
// the frame result is registered at the output once the last pixel of a frame has passed the pixel stage register
// a result waiting at the output stalls the input only at the next frame end
// reset: synchronous, active low; clears position, window and count, and sets config to its defaults
module big_defect_window_detect #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [bdwd_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bdwd_pkg::PIX_W-1:0]      s_tdata,    // [7:0] pixel_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bdwd_pkg::TDATA_W-1:0]    m_tdata     // [23:0] hit_count, [24] big_defect_found
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [bdwd_pkg::CFG_W-1:0] width_reg, height_reg;
    logic                       accept, advance, wr_en;
    logic [CW-1:0]              rd_addr, s1_addr;
    logic                       s1_valid;
    bdwd_pkg::pix_info_t        s1_info;
    logic [bdwd_pkg::STORE_W-1:0] old_bits, wr_data;
    logic [bdwd_pkg::HIT_W-1:0] hit_count;
    logic                       big_defect_found;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= bdwd_pkg::WIDTH_DEFAULT;
            height_reg <= bdwd_pkg::HEIGHT_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bdwd_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wr_data;
                end
                bdwd_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                default: begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    bdwd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .image_width  (width_reg),
        .image_height (height_reg),
        .accept       (accept),
        .pixel_value  (s_tdata),
        .advance      (advance),
        .rd_addr      (rd_addr),
        .s1_valid     (s1_valid),
        .s1_info      (s1_info),
        .s1_addr      (s1_addr)
    );

    bdwd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (wr_data),
        .rd_data (old_bits)
    );

    bdwd_score u_score (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s1_valid         (s1_valid),
        .s1_info          (s1_info),
        .old_bits         (old_bits),
        .m_tready         (m_tready),
        .advance          (advance),
        .wr_en            (wr_en),
        .wr_data          (wr_data),
        .m_tvalid         (m_tvalid),
        .hit_count        (hit_count),
        .big_defect_found (big_defect_found)
    );

    assign m_tdata = {{(bdwd_pkg::TDATA_W-bdwd_pkg::HIT_W-1){1'b0}}, big_defect_found, hit_count};

endmodule
